FILE: src/vrp_pkg.sv
// Package for the vertex rotate and project pipeline.
// Holds payload and configuration types, register indexes and the
// saturation and truncation helpers shared by all pipeline cells.
package vrp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int WIDE = 72;

  // sqrt(3)/2 as unsigned Q0.32, rounded to nearest.
  localparam logic [63:0] COS30_Q32 = 64'd3719550787;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZOOM = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_X = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Y = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Z = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEPTH_OFF = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_X_OFF = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_Y_OFF = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ISO_EN = 3'd7;

  localparam logic [31:0] SINCOS_RESET = 32'h4000_0000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_z;
  } result_t;

  typedef struct packed {
    logic signed [15:0] depth_offset;
    logic signed [15:0] screen_x_offset;
    logic signed [15:0] screen_y_offset;
    logic               iso_enable;
  } proj_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
    logic same;
    same = (&v[WIDE-1:31]) || (~|v[WIDE-1:31]);
    if (same) begin
      return v[31:0];
    end else if (v[WIDE-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // Divide by 2^f, rounding toward zero.
  function automatic logic signed [WIDE-1:0] trunc_frac(input logic signed [WIDE-1:0] v,
                                                        input int f);
    logic signed [WIDE-1:0] bias;
    bias = (WIDE'(1) <<< f) - WIDE'(1);
    if (v[WIDE-1]) begin
      return (v + bias) >>> f;
    end else begin
      return v >>> f;
    end
  endfunction

endpackage

FILE: src/vrp_rot_cell.sv
// One rotation cell of the pipeline: a plane rotation of two coordinates.
// Depends on vrp_pkg. Two stages: products, then sum, truncation, saturation.
module vrp_rot_cell #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] in_b,
  input  logic signed [31:0] in_pass,
  input  logic        [31:0] sincos,
  output logic               out_valid,
  output logic signed [31:0] out_a,
  output logic signed [31:0] out_b,
  output logic signed [31:0] out_pass
);
  import vrp_pkg::*;

  logic signed [15:0] cos_v;
  logic signed [15:0] sin_v;
  logic signed [47:0] p_ac;
  logic signed [47:0] p_bs;
  logic signed [47:0] p_as;
  logic signed [47:0] p_bc;
  logic signed [31:0] pass_a;
  logic               valid_a;
  logic signed [WIDE-1:0] sum_a;
  logic signed [WIDE-1:0] sum_b;

  assign cos_v = sincos[31:16];
  assign sin_v = sincos[15:0];

  always_ff @(posedge clk) begin
    p_ac <= 48'(in_a) * 48'(cos_v);
    p_bs <= 48'(in_b) * 48'(sin_v);
    p_as <= 48'(in_a) * 48'(sin_v);
    p_bc <= 48'(in_b) * 48'(cos_v);
    pass_a <= in_pass;
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
  end

  assign sum_a = WIDE'(p_ac) - WIDE'(p_bs);
  assign sum_b = WIDE'(p_as) + WIDE'(p_bc);

  always_ff @(posedge clk) begin
    out_a <= sat32(trunc_frac(sum_a, TRIG_FRAC_BITS));
    out_b <= sat32(trunc_frac(sum_b, TRIG_FRAC_BITS));
    out_pass <= pass_a;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_a;
    end
  end

endmodule

FILE: src/vrp_proj_cell.sv
// Projection cell: depth offset for nonzero depths, optional isometric projection, screen offsets.
// Depends on vrp_pkg. Four stages, output registers in the last one.
module vrp_proj_cell #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  vrp_pkg::proj_cfg_t cfg,
  input  logic               in_valid,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_valid,
  output vrp_pkg::result_t   out_result
);
  import vrp_pkg::*;

  localparam int CW = TRIG_FRAC_BITS + 2;
  localparam int PW = 33 + CW;
  localparam int NYW = 34 + TRIG_FRAC_BITS;
  localparam logic [63:0] C30_U =
    (COS30_Q32 + (64'd1 << (31 - TRIG_FRAC_BITS))) >> (32 - TRIG_FRAC_BITS);
  localparam logic signed [CW-1:0] C30 = C30_U[CW-1:0];

  logic               v1, v2, v3;
  logic signed [31:0] x1, y1, z1;
  logic signed [32:0] diff1, sum1;
  logic signed [31:0] x2, y2, z2;
  logic signed [PW-1:0] prod2;
  logic signed [NYW-1:0] ny2;
  logic signed [31:0] x3, y3, z3;
  logic signed [WIDE-1:0] z_off;

  assign z_off = WIDE'(in_z) + WIDE'(cfg.depth_offset);

  always_ff @(posedge clk) begin
    x1 <= in_x;
    y1 <= in_y;
    z1 <= (in_z != 32'sd0) ? sat32(z_off) : in_z;
    diff1 <= 33'(in_x) - 33'(in_y);
    sum1 <= 33'(in_x) + 33'(in_y);

    x2 <= x1;
    y2 <= y1;
    z2 <= z1;
    prod2 <= PW'(diff1) * PW'(C30);
    ny2 <= (NYW'(sum1) <<< (TRIG_FRAC_BITS - 1)) - (NYW'(z1) <<< TRIG_FRAC_BITS);

    z3 <= z2;
    if (cfg.iso_enable) begin
      x3 <= sat32(trunc_frac(WIDE'(prod2), TRIG_FRAC_BITS));
      y3 <= sat32(trunc_frac(WIDE'(ny2), TRIG_FRAC_BITS));
    end else begin
      x3 <= x2;
      y3 <= y2;
    end

    out_result.screen_x <= sat32(WIDE'(x3) + WIDE'(cfg.screen_x_offset));
    out_result.screen_y <= sat32(WIDE'(y3) + WIDE'(cfg.screen_y_offset));
    out_result.depth_z <= z3;

    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

endmodule

FILE: src/vertex_rotate_project.sv
// Vertex rotate and project: scale, rotate about X, Y, Z, then project.
// One transaction may be accepted every cycle, and busy is high only during
// reset. The pipeline depth is set by a scale stage, three two-stage rotation
// cells and a four-stage projection cell. Synchronous reset clears all valid
// flags and restores the register defaults; results cannot be stalled by the
// receiver.
module vertex_rotate_project #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  vrp_pkg::point_t                        point,
  output logic                                   done,
  output vrp_pkg::result_t                       result,
  input  logic                                   cfg_we,
  input  logic [vrp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [vrp_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
  import vrp_pkg::*;

  localparam int LAT = 11;
  localparam int MULW = COORD_WIDTH + 9;

  logic [7:0]  zoom_factor;
  logic [31:0] rot_x_sincos;
  logic [31:0] rot_y_sincos;
  logic [31:0] rot_z_sincos;
  proj_cfg_t   pcfg;

  logic               accept;
  logic               s_valid;
  logic signed [31:0] s_x, s_y, s_z;
  logic signed [MULW-1:0] m_x, m_y, m_z;
  logic signed [8:0]  zoom_s;

  logic               rx_valid, ry_valid, rz_valid;
  logic signed [31:0] rx_z, rx_y, rx_x;
  logic signed [31:0] ry_x, ry_z, ry_y;
  logic signed [31:0] rz_x, rz_y, rz_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_factor <= 8'd1;
      rot_x_sincos <= SINCOS_RESET;
      rot_y_sincos <= SINCOS_RESET;
      rot_z_sincos <= SINCOS_RESET;
      pcfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZOOM:         zoom_factor <= cfg_data[7:0];
        REG_ROT_X:        rot_x_sincos <= cfg_data;
        REG_ROT_Y:        rot_y_sincos <= cfg_data;
        REG_ROT_Z:        rot_z_sincos <= cfg_data;
        REG_DEPTH_OFF:    pcfg.depth_offset <= cfg_data[15:0];
        REG_SCREEN_X_OFF: pcfg.screen_x_offset <= cfg_data[15:0];
        REG_SCREEN_Y_OFF: pcfg.screen_y_offset <= cfg_data[15:0];
        REG_ISO_EN:       pcfg.iso_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = rst;
  assign accept = start && !busy;

  assign zoom_s = {1'b0, zoom_factor};
  assign m_x = MULW'(point.point_x) * MULW'(zoom_s);
  assign m_y = MULW'(point.point_y) * MULW'(zoom_s);
  assign m_z = MULW'(point.point_z) * MULW'(zoom_s);

  always_ff @(posedge clk) begin
    s_x <= sat32(WIDE'(m_x));
    s_y <= sat32(WIDE'(m_y));
    s_z <= sat32(WIDE'(m_z));
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
    end
  end

  vrp_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk(clk), .rst(rst), .in_valid(s_valid),
    .in_a(s_z), .in_b(s_y), .in_pass(s_x), .sincos(rot_x_sincos),
    .out_valid(rx_valid), .out_a(rx_z), .out_b(rx_y), .out_pass(rx_x)
  );

  vrp_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk(clk), .rst(rst), .in_valid(rx_valid),
    .in_a(rx_x), .in_b(rx_z), .in_pass(rx_y), .sincos(rot_y_sincos),
    .out_valid(ry_valid), .out_a(ry_x), .out_b(ry_z), .out_pass(ry_y)
  );

  vrp_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk(clk), .rst(rst), .in_valid(ry_valid),
    .in_a(ry_x), .in_b(ry_y), .in_pass(ry_z), .sincos(rot_z_sincos),
    .out_valid(rz_valid), .out_a(rz_x), .out_b(rz_y), .out_pass(rz_z)
  );

  vrp_proj_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_proj (
    .clk(clk), .rst(rst), .cfg(pcfg), .in_valid(rz_valid),
    .in_x(rz_x), .in_y(rz_y), .in_z(rz_z),
    .out_valid(done), .out_result(result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted transaction did not complete after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("done strobe without a matching accepted transaction");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done strobe right after reset");

endmodule

FILE: bench/tb_vertex_rotate_project.sv
// Testbench for vertex_rotate_project: scaled, rotated and projected map points
// are checked against a predictor kept in the bench. Depends on vrp_pkg and
// the vertex_rotate_project top level only.
module tb_vertex_rotate_project;
  import vrp_pkg::*;

  localparam int FRAC = 14;
  localparam longint ISO_COS30 =
    longint'((64'd3719550787 + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
  localparam longint ISO_SIN30 = longint'(64'd1 << (FRAC - 1));
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0]         zoom;
    logic [31:0]        rot_x;
    logic [31:0]        rot_y;
    logic [31:0]        rot_z;
    logic signed [15:0] depth_off;
    logic signed [15:0] sx_off;
    logic signed [15:0] sy_off;
    logic               iso;
  } view_cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  point_t point = '0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic busy;
  logic done;
  result_t result;

  view_cfg_t view;
  result_t expected_q[$];
  result_t want;
  int mismatch_count = 0;
  int cycle_count = 0;

  vertex_rotate_project #(.TRIG_FRAC_BITS(FRAC)) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .point(point),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint trunc_q(longint v);
    if (v < 0) return -((-v) >>> FRAC);
    return v >>> FRAC;
  endfunction

  function automatic result_t project_point(point_t p);
    longint x, y, z, c, s, t;
    result_t r;
    x = clamp_s32(longint'($signed(p.point_x)) * longint'(view.zoom));
    y = clamp_s32(longint'($signed(p.point_y)) * longint'(view.zoom));
    z = clamp_s32(longint'($signed(p.point_z)) * longint'(view.zoom));
    c = longint'($signed(view.rot_x[31:16]));
    s = longint'($signed(view.rot_x[15:0]));
    t = clamp_s32(trunc_q(y * c + z * s));
    z = clamp_s32(trunc_q(z * c - y * s));
    y = t;
    c = longint'($signed(view.rot_y[31:16]));
    s = longint'($signed(view.rot_y[15:0]));
    t = clamp_s32(trunc_q(x * c - z * s));
    z = clamp_s32(trunc_q(x * s + z * c));
    x = t;
    c = longint'($signed(view.rot_z[31:16]));
    s = longint'($signed(view.rot_z[15:0]));
    t = clamp_s32(trunc_q(x * c - y * s));
    y = clamp_s32(trunc_q(x * s + y * c));
    x = t;
    if (z != 0) begin
      z = clamp_s32(z + longint'(view.depth_off));
    end
    if (view.iso) begin
      t = clamp_s32(trunc_q((x - y) * ISO_COS30));
      y = clamp_s32(trunc_q((x + y) * ISO_SIN30 - (z <<< FRAC)));
      x = t;
    end
    x = clamp_s32(x + longint'(view.sx_off));
    y = clamp_s32(y + longint'(view.sy_off));
    r.screen_x = 32'(x);
    r.screen_y = 32'(y);
    r.depth_z = 32'(z);
    return r;
  endfunction

  function automatic view_cfg_t make_view(logic [7:0] zoom, logic [31:0] rx, logic [31:0] ry,
                                          logic [31:0] rz, logic [15:0] doff,
                                          logic [15:0] xoff, logic [15:0] yoff, logic iso);
    view_cfg_t v;
    v.zoom = zoom;
    v.rot_x = rx;
    v.rot_y = ry;
    v.rot_z = rz;
    v.depth_off = doff;
    v.sx_off = xoff;
    v.sy_off = yoff;
    v.iso = iso;
    return v;
  endfunction

  function automatic view_cfg_t random_view();
    view_cfg_t v;
    logic [31:0] corner_sc[6] = '{32'h8000_8000, 32'h7fff_7fff, 32'h4000_0000,
                                  32'h0000_4000, 32'h8000_7fff, 32'h0000_0000};
    logic [15:0] corner_off[3] = '{16'h8000, 16'h7fff, 16'h0000};
    logic [31:0] sc[3];
    logic [15:0] off[3];
    real a;
    int c, s;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0: sc[i] = corner_sc[$urandom_range(0, 5)];
        1: sc[i] = $urandom;
        default: begin
          a = $urandom_range(0, 359) * 3.141592653589793 / 180.0;
          c = $rtoi($cos(a) * 16384.0);
          s = $rtoi($sin(a) * 16384.0);
          sc[i] = {c[15:0], s[15:0]};
        end
      endcase
      off[i] = ($urandom_range(0, 3) == 0) ? corner_off[$urandom_range(0, 2)]
                                           : 16'($urandom);
    end
    if ($urandom_range(0, 7) == 0) begin
      v.zoom = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd1;
    end else begin
      v.zoom = 8'($urandom_range(1, 255));
    end
    v.rot_x = sc[0];
    v.rot_y = sc[1];
    v.rot_z = sc[2];
    v.depth_off = off[0];
    v.sx_off = off[1];
    v.sy_off = off[2];
    v.iso = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic point_t random_point();
    point_t p;
    logic [15:0] corners[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      p.point_x = corners[$urandom_range(0, 4)];
      p.point_y = corners[$urandom_range(0, 4)];
      p.point_z = corners[$urandom_range(0, 4)];
    end else if (pick <= 3) begin
      p.point_x = 16'($urandom_range(0, 200) - 100);
      p.point_y = 16'($urandom_range(0, 200) - 100);
      p.point_z = 16'($urandom_range(0, 200) - 100);
    end else begin
      p.point_x = 16'($urandom);
      p.point_y = 16'($urandom);
      p.point_z = 16'($urandom);
    end
    return p;
  endfunction

  task automatic put_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_view(view_cfg_t v);
    logic [31:0] noise;
    noise = $urandom;
    put_reg(REG_ZOOM, {noise[31:8], v.zoom});
    put_reg(REG_ROT_X, v.rot_x);
    put_reg(REG_ROT_Y, v.rot_y);
    put_reg(REG_ROT_Z, v.rot_z);
    put_reg(REG_DEPTH_OFF, {noise[15:0], v.depth_off});
    put_reg(REG_SCREEN_X_OFF, {noise[31:16], v.sx_off});
    put_reg(REG_SCREEN_Y_OFF, {noise[23:8], v.sy_off});
    put_reg(REG_ISO_EN, {noise[31:1], v.iso});
    cfg_we <= 1'b0;
    view = v;
  endtask

  task automatic send_point(point_t p);
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(project_point(p));
  endtask

  task automatic idle_for(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp) begin
      report_failure($sformatf("Mismatch in %s: expected %0d (%h), got %0d (%h)",
                               name, $signed(exp), exp, $signed(got), got));
    end
  endtask

  task automatic test_reset_defaults();
    logic [47:0] corner_points[6] = '{48'h0000_0000_0000, 48'h7fff_7fff_7fff,
                                      48'h8000_8000_8000, 48'h7fff_8000_0001,
                                      48'hffff_ffff_ffff, 48'h5555_aaaa_5555};
    foreach (corner_points[i]) send_point(corner_points[i]);
    drain();
  endtask

  task automatic test_zoom_zero();
    apply_view(make_view(8'd0, 32'h2d41_2d41, 32'h3b21_187e, 32'h8000_7fff,
                         16'h1234, 16'h8000, 16'h7fff, 1'b1));
    send_point({16'sd1234, -16'sd567, 16'sd89});
    drain();
  endtask

  task automatic test_zero_depth();
    apply_view(make_view(8'd1, 32'h0000_4000, SINCOS_RESET, SINCOS_RESET,
                         16'h7fff, 16'h0010, 16'hfff0, 1'b0));
    send_point({16'sd10, 16'sd0, 16'sd20});
    send_point({16'sd10, 16'sd3, 16'sd20});
    send_point({16'sd0, 16'sd0, 16'sd0});
    drain();
  endtask

  task automatic test_saturation();
    apply_view(make_view(8'd255, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                         16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
    send_point(48'h7fff_7fff_7fff);
    send_point(48'h8000_8000_8000);
    send_point(48'h7fff_8000_7fff);
    drain();
    apply_view(make_view(8'd255, 32'h7fff_8000, 32'h8000_7fff, 32'h7fff_7fff,
                         16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_point(48'h8000_7fff_8000);
    send_point(48'h7fff_7fff_8000);
    send_point(48'h8000_8000_7fff);
    drain();
  endtask

  task automatic test_random_traffic();
    int gap_pct[3] = '{0, 78, 18};
    foreach (gap_pct[ph]) begin
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        apply_view(random_view());
        repeat (100) begin
          idle_for(gap_pct[ph]);
          send_point(random_point());
        end
      end
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_failure($sformatf("Unexpected result: %h", result));
      end else begin
        want = expected_q.pop_front();
        check_field("screen_x", result.screen_x, want.screen_x);
        check_field("screen_y", result.screen_y, want.screen_y);
        check_field("depth_z", result.depth_z, want.depth_z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    view = make_view(8'd1, SINCOS_RESET, SINCOS_RESET, SINCOS_RESET,
                     16'h0000, 16'h0000, 16'h0000, 1'b0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zoom_zero();
    test_zero_depth();
    test_saturation();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
